// ===== src/dnsq_pkg.sv =====
`timescale 1ns / 1ps

package dnsq_pkg;

   localparam logic [3:0]  MaxLabels       = 4'd10;
   localparam logic [7:0]  LabelCopyLimit  = 8'd63;
   localparam logic [7:0]  CompressionMark = 8'hC0;
   localparam logic [7:0]  CharUpperA      = 8'h41;
   localparam logic [7:0]  CharUpperZ      = 8'h5A;
   localparam logic [7:0]  CaseOffset      = 8'd32;
   localparam logic [7:0]  CharDot         = 8'h2E;
   localparam logic [31:0] FnvBasis        = 32'd2166136261;
   localparam logic [31:0] FnvPrime        = 32'd16777619;
   localparam logic [8:0]  CapacityReset   = 9'd256;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       start_of_name;
      logic       packet_ended;
   } req_type;

   typedef struct packed {
      logic        char_valid;
      logic [7:0]  out_char;
      logic        name_done;
      logic [7:0]  name_length;
      logic [31:0] name_hash;
      logic        read_error;
   } rsp_type;

endpackage

// ===== src/dnsq_decode.sv =====
`timescale 1ns / 1ps

module dnsq_decode
   import dnsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    req,
   input  logic [7:0] text_limit,
   output rsp_type    rsp
);

   typedef enum logic [1:0] {
      PH_LENGTH,
      PH_LABEL,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  remain_ff, remain_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  pos_ff, pos_in;
   logic [31:0] hash_ff, hash_in;

   always_comb begin
      phase_type   cur_phase;
      logic [3:0]  cur_count;
      logic [7:0]  cur_remain;
      logic [7:0]  cur_index;
      logic [7:0]  cur_pos;
      logic [31:0] cur_hash;
      logic [7:0]  remain_dec;
      logic        emit_en;
      logic        finish;
      logic [7:0]  emit_ch;
      logic [31:0] hash_x;

      cur_phase  = phase_ff;
      cur_count  = count_ff;
      cur_remain = remain_ff;
      cur_index  = index_ff;
      cur_pos    = pos_ff;
      cur_hash   = hash_ff;
      if (req.start_of_name) begin
         cur_phase  = PH_LENGTH;
         cur_count  = '0;
         cur_remain = '0;
         cur_index  = '0;
         cur_pos    = '0;
         cur_hash   = FnvBasis;
      end

      phase_in   = cur_phase;
      count_in   = cur_count;
      remain_in  = cur_remain;
      index_in   = cur_index;
      rsp        = '0;
      emit_en    = 1'b0;
      finish     = 1'b0;
      emit_ch    = CharDot;
      remain_dec = cur_remain - 8'd1;

      if (req.packet_ended) begin
         if (cur_phase != PH_DONE) begin
            phase_in       = PH_DONE;
            rsp.name_done  = 1'b1;
            rsp.read_error = 1'b1;
         end
      end else begin
         case (cur_phase)
            PH_LENGTH: begin
               if (req.name_byte == 8'd0 || req.name_byte >= CompressionMark) begin
                  finish = 1'b1;
               end else begin
                  remain_in = req.name_byte;
                  index_in  = '0;
                  count_in  = cur_count + 4'd1;
                  phase_in  = PH_LABEL;
                  emit_en   = (cur_pos != 8'd0) && (cur_pos < text_limit);
               end
            end
            PH_LABEL: begin
               if (cur_index < LabelCopyLimit && cur_pos < text_limit) begin
                  emit_en = 1'b1;
                  emit_ch = req.name_byte;
                  if (req.name_byte inside {[CharUpperA:CharUpperZ]}) begin
                     emit_ch = req.name_byte + CaseOffset;
                  end
               end
               index_in  = cur_index + 8'd1;
               remain_in = remain_dec;
               if (remain_dec == 8'd0) begin
                  if (cur_count >= MaxLabels) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_LENGTH;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      hash_x  = cur_hash ^ {24'd0, emit_ch};
      hash_in = emit_en ? hash_x * FnvPrime : cur_hash;
      pos_in  = emit_en ? cur_pos + 8'd1 : cur_pos;

      if (emit_en) begin
         rsp.char_valid = 1'b1;
         rsp.out_char   = emit_ch;
      end
      if (finish) begin
         phase_in        = PH_DONE;
         rsp.name_done   = 1'b1;
         rsp.name_length = pos_in;
         rsp.name_hash   = hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LENGTH;
         count_ff  <= '0;
         remain_ff <= '0;
         index_ff  <= '0;
         pos_ff    <= '0;
         hash_ff   <= FnvBasis;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         index_ff  <= index_in;
         pos_ff    <= pos_in;
         hash_ff   <= hash_in;
      end
   end

endmodule

// ===== src/dns_qname_extract_hash.sv =====
`timescale 1ns / 1ps

// DNS query name decoder with FNV-1a hash. Feed the name field one byte per word,
// marking its first length byte with start_of_name; every word gives exactly one
// result word: a lowercased text character or dot when char_valid is set, and on
// name_done the text length and 32-bit FNV-1a hash (or read_error if packet_ended
// arrived first). One word is taken per cycle, back to back, while rsp_ready stays
// high; a word passes through an input register and a result register, with the
// state update and constant multiply of the hash in between. name_capacity
// (csr_word, reset 256) limits the text to capacity minus one characters and should
// be written only while no name is in flight. From 256 up the limit is 255; 0 allows none.

module dns_qname_extract_hash
   import dnsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_word,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_word
);

   logic       in_valid_ff;
   req_type    in_word_ff;
   logic       out_valid_ff;
   rsp_type    out_word_ff;
   logic [8:0] capacity_ff;
   logic [7:0] text_limit;
   logic       advance;
   rsp_type    step_rsp;

   always_comb begin
      if (capacity_ff[8]) begin
         text_limit = 8'hFF;
      end else if (capacity_ff == 9'd0) begin
         text_limit = 8'd0;
      end else begin
         text_limit = capacity_ff[7:0] - 8'd1;
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;
   assign csr_ready = 1'b1;

   dnsq_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .req        (in_word_ff),
      .text_limit (text_limit),
      .rsp        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         capacity_ff  <= CapacityReset;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            capacity_ff <= csr_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

endmodule

// ===== tb/sv/tb_dns_qname_extract_hash.sv =====
`timescale 1ns / 1ps

module tb_dns_qname_extract_hash;
   import dnsq_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PRINT_LIMIT     = 40;

   typedef enum logic [1:0] {SEEK_LENGTH, IN_LABEL, NAME_OVER} name_phase_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_word;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_word;
   logic       csr_valid;
   logic       csr_ready;
   logic [8:0] csr_word;

   dns_qname_extract_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_word  (csr_word)
   );

   // decoder state as predicted
   logic [8:0]     capacity;
   name_phase_type phase;
   logic [3:0]     label_count;
   logic [7:0]     label_remaining;
   logic [7:0]     label_index;
   logic [7:0]     text_pos;
   logic [31:0]    running_hash;

   rsp_type     expected_words[$];
   logic [7:0]  name_bytes[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   bit          rsp_hold_req = 1'b0;
   int          rsp_hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[dns_qname_extract_hash] ERROR");
         $finish;
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, field, want, got);
      end
   endtask

   task automatic clear_name_state();
      phase = SEEK_LENGTH;
      label_count = 4'd0;
      label_remaining = 8'd0;
      label_index = 8'd0;
      text_pos = 8'd0;
      running_hash = FnvBasis;
   endtask

   task automatic emit_char(input logic [7:0] ch, inout rsp_type r);
      running_hash = (running_hash ^ {24'd0, ch}) * FnvPrime;
      text_pos = text_pos + 8'd1;
      r.char_valid = 1'b1;
      r.out_char = ch;
   endtask

   task automatic close_name(inout rsp_type r);
      phase = NAME_OVER;
      r.name_done = 1'b1;
      r.name_length = text_pos;
      r.name_hash = running_hash;
   endtask

   task automatic predict_word(input req_type w);
      rsp_type    r;
      logic [7:0] lim;
      logic [7:0] ch;
      r = '0;
      if (capacity == 9'd0)
         lim = 8'd0;
      else if (capacity >= 9'd256)
         lim = 8'd255;
      else
         lim = capacity[7:0] - 8'd1;
      if (w.start_of_name)
         clear_name_state();
      if (w.packet_ended) begin
         if (phase != NAME_OVER) begin
            phase = NAME_OVER;
            r.name_done = 1'b1;
            r.read_error = 1'b1;
         end
      end else if (phase == SEEK_LENGTH) begin
         if (w.name_byte == 8'd0 || w.name_byte >= CompressionMark) begin
            close_name(r);
         end else begin
            label_remaining = w.name_byte;
            label_index = 8'd0;
            label_count = label_count + 4'd1;
            phase = IN_LABEL;
            if (text_pos > 8'd0 && text_pos < lim)
               emit_char(CharDot, r);
         end
      end else if (phase == IN_LABEL) begin
         if (label_index < LabelCopyLimit && text_pos < lim) begin
            ch = w.name_byte;
            if (ch >= CharUpperA && ch <= CharUpperZ)
               ch = ch + CaseOffset;
            emit_char(ch, r);
         end
         label_index = label_index + 8'd1;
         label_remaining = label_remaining - 8'd1;
         if (label_remaining == 8'd0) begin
            if (label_count >= MaxLabels)
               close_name(r);
            else
               phase = SEEK_LENGTH;
         end
      end
      expected_words.push_back(r);
   endtask

   // receiver: random stalls, long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_left = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            check_field("unexpected word, hash", 32'd0, rsp_word.name_hash);
            check_field("unexpected word", 32'd0, 32'd1);
         end else begin
            want = expected_words.pop_front();
            check_field("char_valid", 32'(want.char_valid), 32'(rsp_word.char_valid));
            check_field("out_char", 32'(want.out_char), 32'(rsp_word.out_char));
            check_field("name_done", 32'(want.name_done), 32'(rsp_word.name_done));
            check_field("name_length", 32'(want.name_length),
                        32'(rsp_word.name_length));
            check_field("name_hash", want.name_hash, rsp_word.name_hash);
            check_field("read_error", 32'(want.read_error), 32'(rsp_word.read_error));
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic start, input logic ended);
      req_type w;
      w.name_byte = b;
      w.start_of_name = start;
      w.packet_ended = ended;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      predict_word(w);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [8:0] value);
      drain_results(4);
      csr_valid <= 1'b1;
      csr_word <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity = value;
   endtask

   // cut < 0 sends the whole name, else packet ends in place of byte cut
   task automatic send_name_bytes(input int cut);
      for (int i = 0; i < name_bytes.size(); i++) begin
         if (i == cut) begin
            send_word(8'($urandom_range(255)), i == 0, 1'b1);
            break;
         end
         send_word(name_bytes[i], i == 0, 1'b0);
      end
   endtask

   task automatic build_random_name();
      int n_labels;
      int len;
      int pick;
      name_bytes.delete();
      n_labels = ($urandom_range(99) < 10) ? $urandom_range(10, 12) : $urandom_range(1, 5);
      for (int l = 0; l < n_labels; l++) begin
         pick = $urandom_range(99);
         if (pick < 85)
            len = $urandom_range(1, 12);
         else if (pick < 95)
            len = $urandom_range(60, 70);
         else
            len = $urandom_range(1, 191);
         name_bytes.push_back(8'(len));
         for (int c = 0; c < len; c++) begin
            pick = $urandom_range(99);
            if (pick < 35)
               name_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            else if (pick < 70)
               name_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else
               name_bytes.push_back(8'($urandom_range(255)));
         end
      end
      pick = $urandom_range(99);
      if (pick < 70)
         name_bytes.push_back(8'd0);
      else if (pick < 90)
         name_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
   endtask

   task automatic send_random_stream(input int n_items);
      int sent;
      int pick;
      int cut;
      int n;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 90) begin
            build_random_name();
            cut = (pick < 78) ? -1 : $urandom_range(0, name_bytes.size() - 1);
            send_name_bytes(cut);
            sent += (cut < 0) ? name_bytes.size() : cut + 1;
            if ($urandom_range(99) < 15) begin
               n = $urandom_range(1, 3);
               repeat (n) send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                                 $urandom_range(99) < 25);
            sent += n;
         end
      end
   endtask

   task automatic test_directed();
      req_gap_pct = 24;
      rsp_stall_pct = 76;
      name_bytes = '{8'd3, 8'h41, 8'h7A, 8'h5A, 8'd2, 8'h40, 8'h5B, 8'd0};
      send_name_bytes(-1);
      name_bytes = '{8'd1, 8'h78, CompressionMark};
      send_name_bytes(-1);
      name_bytes = '{8'hFF};
      send_name_bytes(-1);
      name_bytes = '{8'd2, 8'h71, 8'h72};
      send_name_bytes(2);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hA5, 1'b0, 1'b1);
      send_word(8'h3C, 1'b1, 1'b1);
   endtask

   task automatic test_capacity_sweep();
      logic [8:0] caps[$];
      req_gap_pct = 10;
      rsp_stall_pct = 10;
      caps = '{9'd2, 9'd0, 9'd1, 9'd511, 9'd257, 9'd3, 9'($urandom_range(2, 256)), 9'd256};
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         send_random_stream(20);
      end
   endtask

   task automatic test_random_traffic();
      int gaps[3];
      int stalls[3];
      gaps = '{24, 76, 0};
      stalls = '{76, 24, 0};
      for (int r = 0; r < 3; r++) begin
         req_gap_pct = gaps[r];
         rsp_stall_pct = stalls[r];
         if (r == 2)
            write_capacity(9'd256);
         else if ($urandom_range(1))
            write_capacity(9'($urandom_range(2, 24)));
         else
            write_capacity(9'($urandom_range(2, 256)));
         send_random_stream(330);
      end
   endtask

   task automatic test_backpressure();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_req = 1'b1;
      send_random_stream(100);
      drain_results(0);
      send_random_stream(40);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_word = '0;
      capacity = CapacityReset;
      clear_name_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_sweep();
      test_random_traffic();
      test_backpressure();
      drain_results(8);
      if (error_count == 0)
         $display("[dns_qname_extract_hash] OK");
      else
         $display("[dns_qname_extract_hash] ERROR");
      $finish;
   end

endmodule
